// ----- hdl/ole_pkg.sv -----
// Package for the ordered list engine: sizes, mode and status codes, sequencer states.
// No dependencies.
package ole_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  typedef enum logic [3:0] {
    MODE_INS_FRONT = 4'd0,
    MODE_INS_BACK  = 4'd1,
    MODE_INS_POS   = 4'd2,
    MODE_DEL_FRONT = 4'd3,
    MODE_DEL_BACK  = 4'd4,
    MODE_DEL_VALUE = 4'd5,
    MODE_SEARCH    = 4'd6,
    MODE_COUNT     = 4'd7,
    MODE_REVERSE   = 4'd8,
    MODE_READ_ALL  = 4'd9
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_SWAP,
    S_READ
  } state_e;

  // Steps of one swap of a front and a back entry
  typedef enum logic [1:0] {
    PH_READ_A,
    PH_READ_B,
    PH_WRITE_A
  } swap_phase_e;

  // Memory port command from the sequencer to the store.
  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [31:0]     wr_data;
  } mem_cmd_t;

endpackage

// ----- hdl/ordered_list_engine.sv -----
// Top level of the ordered list engine: sequencer walking the store one entry a cycle, reverse apart.
// Depends on ole_pkg and ole_store.
//
// channel  | direction | handshake                | payload
// request  | in        | start & !busy            | mode_i, value_i, position_i
// result   | out       | valid_o (one cycle each) | result_value_o, status_o, found_o,
//          |           |                          | element_count_o, last_o
//
// A read-all streams its results back to back, one per stored entry.
// Count, spare codes and rejected requests keep busy low; their result follows next cycle.
// The final result shows in the first cycle with busy low, so a new request may transfer then.
// Reset clears the count and the sequencer; the store holds no reset value.
module ordered_list_engine import ole_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  mode_i,
  input  logic signed [31:0] value_i,
  input  logic [7:0]  position_i,
  output logic        valid_o,
  output logic signed [31:0] result_value_o,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [4:0]  element_count_o,
  output logic        last_o
);

  state_e          state_q, state_d;
  swap_phase_e     phase_q, phase_d;
  logic [3:0]      mode_q;
  logic [31:0]     value_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] i_q, i_d;      // next index to read
  logic [CntW-1:0] j_q, j_d;      // insert point or back end of a swap
  logic [CntW-1:0] ri_q, ri_d;    // index that the read data belongs to
  logic            rv_q, rv_d;    // read data valid this cycle
  logic [31:0]     hold_q, hold_d;
  logic            wb_q, wb_d;    // saved front entry waits to be written back
  logic            out_q, out_d;
  logic [31:0]     res_q, res_d;
  logic [1:0]      st_q, st_d;
  logic            fnd_q, fnd_d;
  logic            last_q, last_d;
  logic [CntW-1:0] ecnt_q, ecnt_d;
  logic [31:0]     rd_data;
  mem_cmd_t        cmd;
  logic            accept;
  logic            list_full;
  logic            list_empty;
  logic            any_del;
  logic            scan_hit;
  logic            walk_end;
  logic            up_end;
  logic            swap_end;
  logic            read_end;
  logic [CntW-1:0] ins_idx;

  assign accept     = start && !busy;
  assign busy       = (state_q != S_IDLE);
  assign list_full  = (cnt_q >= CntW'(Capacity));
  assign list_empty = (cnt_q == '0);
  assign any_del    = (mode_q == MODE_DEL_FRONT) || (mode_q == MODE_DEL_BACK);
  assign scan_hit   = rv_q && (any_del || rd_data == value_q);
  assign walk_end   = !rv_q && (i_q >= cnt_q);
  assign up_end     = !rv_q && (i_q <= j_q);
  assign swap_end   = (phase_q == PH_READ_A) && (i_q >= j_q);
  assign read_end   = rv_q && (ri_q + 1'b1 == cnt_q);

  // Clamp the insert position into the list
  always_comb begin
    priority if (mode_i == MODE_INS_BACK) ins_idx = cnt_q;
    else if (mode_i == MODE_INS_FRONT || position_i <= 8'd1) ins_idx = '0;
    else if (position_i - 8'd1 < 8'(cnt_q)) ins_idx = CntW'(position_i - 8'd1);
    else ins_idx = cnt_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS:
              state_d = list_full ? S_IDLE : S_SHIFT_UP;
            MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_VALUE:
              state_d = list_empty ? S_IDLE : S_SCAN;
            MODE_SEARCH:   state_d = S_SCAN;
            MODE_REVERSE:  state_d = S_SWAP;
            MODE_READ_ALL: state_d = list_empty ? S_IDLE : S_READ;
            default:       state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_hit) state_d = (mode_q == MODE_SEARCH) ? S_IDLE : S_SHIFT_DOWN;
        else if (walk_end) state_d = S_IDLE;
      end
      S_SHIFT_DOWN: if (walk_end) state_d = S_IDLE;
      S_SHIFT_UP:   if (up_end) state_d = S_IDLE;
      S_SWAP:       if (swap_end) state_d = S_IDLE;
      S_READ:       if (read_end) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  // Store command, walk indexes and results
  always_comb begin
    cnt_d   = cnt_q;
    i_d     = i_q;
    j_d     = j_q;
    ri_d    = ri_q;
    rv_d    = 1'b0;
    hold_d  = hold_q;
    phase_d = phase_q;
    wb_d    = wb_q;
    out_d   = 1'b0;
    res_d   = 32'd0;
    st_d    = ST_OK;
    fnd_d   = 1'b0;
    last_d  = 1'b1;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        // Set up the walk, or answer at once
        if (accept) begin
          i_d = '0;
          unique case (mode_i)
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS: begin
              if (list_full) begin
                out_d = 1'b1; st_d = ST_FULL;
              end else begin
                i_d = cnt_q; j_d = ins_idx;
              end
            end
            MODE_DEL_FRONT, MODE_DEL_VALUE, MODE_READ_ALL: begin
              if (list_empty) begin
                out_d = 1'b1; st_d = ST_EMPTY;
              end
            end
            MODE_DEL_BACK: begin
              if (list_empty) begin
                out_d = 1'b1; st_d = ST_EMPTY;
              end else begin
                i_d = cnt_q - 1'b1;
              end
            end
            MODE_SEARCH: ;
            MODE_REVERSE: begin
              j_d = list_empty ? '0 : cnt_q - 1'b1;
              phase_d = PH_READ_A; wb_d = 1'b0;
            end
            default: out_d = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        // Walk from the start index looking for the entry
        if (scan_hit) begin
          if (mode_q == MODE_SEARCH) begin
            out_d = 1'b1; fnd_d = 1'b1;
          end else begin
            hold_d = rd_data; i_d = ri_q + 1'b1;
          end
        end else if (walk_end) begin
          out_d = 1'b1; st_d = ST_NOTFOUND;
        end else if (i_q < cnt_q) begin
          cmd.rd_en = 1'b1; cmd.rd_addr = IdxW'(i_q);
          i_d = i_q + 1'b1; rv_d = 1'b1; ri_d = i_q;
        end
      end
      S_SHIFT_DOWN: begin
        // Move each later entry down by one, then drop the count
        if (rv_q) begin
          cmd.wr_en = 1'b1; cmd.wr_addr = IdxW'(ri_q - 1'b1); cmd.wr_data = rd_data;
        end
        if (i_q < cnt_q) begin
          cmd.rd_en = 1'b1; cmd.rd_addr = IdxW'(i_q);
          i_d = i_q + 1'b1; rv_d = 1'b1; ri_d = i_q;
        end else if (!rv_q) begin
          cnt_d = cnt_q - 1'b1; res_d = hold_q; out_d = 1'b1;
        end
      end
      S_SHIFT_UP: begin
        // Move entries up by one from the back down to the insert point
        if (rv_q) begin
          cmd.wr_en = 1'b1; cmd.wr_addr = IdxW'(ri_q + 1'b1); cmd.wr_data = rd_data;
        end
        if (i_q > j_q) begin
          cmd.rd_en = 1'b1; cmd.rd_addr = IdxW'(i_q - 1'b1);
          i_d = i_q - 1'b1; rv_d = 1'b1; ri_d = i_q - 1'b1;
        end else if (!rv_q) begin
          cmd.wr_en = 1'b1; cmd.wr_addr = IdxW'(j_q); cmd.wr_data = value_q;
          cnt_d = cnt_q + 1'b1; out_d = 1'b1;
        end
      end
      S_SWAP: begin
        // Swap the front and back entries, closing in by one entry from each end per swap
        unique case (phase_q)
          PH_READ_A: begin
            if (wb_q) begin
              cmd.wr_en = 1'b1; cmd.wr_addr = IdxW'(j_q + 1'b1); cmd.wr_data = hold_q;
            end
            wb_d = 1'b0;
            if (swap_end) begin
              out_d = 1'b1;
            end else begin
              cmd.rd_en = 1'b1; cmd.rd_addr = IdxW'(i_q); phase_d = PH_READ_B;
            end
          end
          PH_READ_B: begin
            hold_d = rd_data;
            cmd.rd_en = 1'b1; cmd.rd_addr = IdxW'(j_q); phase_d = PH_WRITE_A;
          end
          PH_WRITE_A: begin
            cmd.wr_en = 1'b1; cmd.wr_addr = IdxW'(i_q); cmd.wr_data = rd_data;
            i_d = i_q + 1'b1; j_d = j_q - 1'b1; wb_d = 1'b1; phase_d = PH_READ_A;
          end
          default: phase_d = PH_READ_A;
        endcase
      end
      S_READ: begin
        // Stream entries front first
        if (i_q < cnt_q) begin
          cmd.rd_en = 1'b1; cmd.rd_addr = IdxW'(i_q);
          i_d = i_q + 1'b1; rv_d = 1'b1; ri_d = i_q;
        end
        if (rv_q) begin
          res_d = rd_data; out_d = 1'b1; last_d = read_end;
        end
      end
      default: ;
    endcase
    ecnt_d = cnt_d;
  end

  // Advance the sequencer and capture the request and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; phase_q <= PH_READ_A; mode_q <= '0; value_q <= '0;
      cnt_q <= '0; i_q <= '0; j_q <= '0; ri_q <= '0; rv_q <= 1'b0;
      hold_q <= '0; wb_q <= 1'b0; out_q <= 1'b0; res_q <= '0; st_q <= '0;
      fnd_q <= 1'b0; last_q <= 1'b0; ecnt_q <= '0;
    end else begin
      state_q <= state_d; phase_q <= phase_d; cnt_q <= cnt_d;
      i_q <= i_d; j_q <= j_d; ri_q <= ri_d; rv_q <= rv_d;
      hold_q <= hold_d; wb_q <= wb_d; out_q <= out_d; res_q <= res_d; st_q <= st_d;
      fnd_q <= fnd_d; last_q <= last_d; ecnt_q <= ecnt_d;
      if (accept) begin
        mode_q <= mode_i; value_q <= value_i;
      end
    end
  end

  ole_store u_store (.clk_i(clk_i), .cmd_i(cmd), .rd_data_o(rd_data));

  assign valid_o         = out_q;
  assign result_value_o  = res_q;
  assign status_o        = st_q;
  assign found_o         = fnd_q;
  assign element_count_o = 5'(ecnt_q);
  assign last_o          = last_q;

  // Count never exceeds the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Capacity))
    else $error("count above capacity");
  // A full status only comes with a full list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_q && st_q == ST_FULL) |-> ecnt_q == CntW'(Capacity))
    else $error("full status on a list with room");
  // A result without last is followed by more of the same read-out
  assert property (@(posedge clk_i) disable iff (!rst_ni) (out_q && !last_q) |-> busy)
    else $error("read-out ended without last");
  // A found flag only comes with ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni) (out_q && fnd_q) |-> st_q == ST_OK)
    else $error("found without ok");

endmodule

// ----- hdl/ole_store.sv -----
// Element store of the ordered list engine: one write port, one registered read port.
// Depends on ole_pkg.
module ole_store import ole_pkg::*; (
  input  logic        clk_i,
  input  mem_cmd_t    cmd_i,
  output logic [31:0] rd_data_o
);

  logic [31:0] mem_q [Capacity];

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem_q[cmd_i.wr_addr] <= cmd_i.wr_data;
    if (cmd_i.rd_en) rd_data_o <= mem_q[cmd_i.rd_addr];
  end

endmodule
